### rtl/kfs_pkg.sv
`timescale 1ns / 1ps

package kfs_pkg;

    localparam int PORTMAP_W = 8;
    localparam int PORT_IDX_W = 3;
    localparam int K_W = 2;

    localparam logic [K_W-1:0] K_NONE  = 2'd0;
    localparam logic [K_W-1:0] K_ONE   = 2'd1;
    localparam logic [K_W-1:0] K_TWO   = 2'd2;
    localparam logic [K_W-1:0] K_THREE = 2'd3;

    // Which input destination fills a destination slot of a copy.
    typedef enum logic [1:0] {
        SEL_NONE = 2'd0,
        SEL_A    = 2'd1,
        SEL_B    = 2'd2,
        SEL_C    = 2'd3
    } t_sel;

    typedef struct packed {
        logic [PORT_IDX_W-1:0] port;
        logic [K_W-1:0]        k;
        t_sel                  sel_a;
        t_sel                  sel_b;
        t_sel                  sel_c;
    } t_copy;

    // Copy list of one request: copies[0] goes out first.
    typedef struct packed {
        logic [1:0]      count;
        t_copy [2:0]     copies;
    } t_plan;

endpackage

### rtl/kfs_front.sv
`timescale 1ns / 1ps

module kfs_front
    import kfs_pkg::*;
#(
    parameter int NUM_PORTS  = 8,
    parameter int ADDR_WIDTH = 16,
    parameter int COST_WIDTH = 16
) (
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [K_W-1:0]        i_k_count,
    input  logic [ADDR_WIDTH-1:0] i_dest_a,
    input  logic [ADDR_WIDTH-1:0] i_dest_b,
    input  logic [ADDR_WIDTH-1:0] i_dest_c,
    input  logic [COST_WIDTH-1:0] i_cost_a,
    input  logic [COST_WIDTH-1:0] i_cost_b,
    input  logic [COST_WIDTH-1:0] i_cost_c,
    input  logic [PORTMAP_W-1:0]  i_ports_a,
    input  logic [PORTMAP_W-1:0]  i_ports_b,
    input  logic [PORTMAP_W-1:0]  i_ports_c,
    input  logic                  i_full,
    output logic                  o_push,
    output t_plan                 o_plan
);

    localparam logic [PORTMAP_W-1:0] PORT_MASK = PORTMAP_W'((1 << NUM_PORTS) - 1);

    localparam logic [1:0] PAIR_AB = 2'd0;
    localparam logic [1:0] PAIR_AC = 2'd1;
    localparam logic [1:0] PAIR_BC = 2'd2;

    localparam logic [1:0] PAIR_LO [3] = '{2'd0, 2'd0, 2'd1};
    localparam logic [1:0] PAIR_HI [3] = '{2'd1, 2'd2, 2'd2};
    localparam t_sel       SELS    [3] = '{SEL_A, SEL_B, SEL_C};

    function automatic logic [PORT_IDX_W-1:0] low_port(input logic [PORTMAP_W-1:0] bm);
        logic [PORT_IDX_W-1:0] r;
        r = '0;
        for (int i = PORTMAP_W - 1; i >= 0; i--) begin
            if (bm[i]) begin
                r = PORT_IDX_W'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [PORT_IDX_W-1:0] high_port(input logic [PORTMAP_W-1:0] bm);
        logic [PORT_IDX_W-1:0] r;
        r = '0;
        for (int i = 0; i < PORTMAP_W; i++) begin
            if (bm[i]) begin
                r = PORT_IDX_W'(i);
            end
        end
        return r;
    endfunction

    function automatic t_copy mk_single(input t_sel s, input logic [PORTMAP_W-1:0] bm);
        t_copy c;
        c       = '0;
        c.port  = low_port(bm);
        c.k     = K_ONE;
        c.sel_a = s;
        return c;
    endfunction

    function automatic t_copy mk_merge(input t_sel s1, input t_sel s2,
                                       input logic [PORTMAP_W-1:0] sh);
        t_copy c;
        c       = '0;
        c.port  = high_port(sh);
        c.k     = K_TWO;
        c.sel_a = s1;
        c.sel_b = s2;
        return c;
    endfunction

    logic [ADDR_WIDTH-1:0] dv [3];
    logic [COST_WIDTH-1:0] cv [3];
    logic [PORTMAP_W-1:0]  pm [3];
    logic [PORTMAP_W-1:0]  share [3];
    logic [PORTMAP_W-1:0]  all_share;
    logic [1:0]            best;
    logic                  have;
    logic [1:0]            tr [3];
    logic [1:0]            ntry;
    logic [1:0]            sp;
    logic                  done;
    t_plan                 plan;

    assign dv[0] = i_dest_a;
    assign dv[1] = i_dest_b;
    assign dv[2] = i_dest_c;
    assign cv[0] = i_cost_a;
    assign cv[1] = i_cost_b;
    assign cv[2] = i_cost_c;
    assign pm[0] = i_ports_a & PORT_MASK;
    assign pm[1] = i_ports_b & PORT_MASK;
    assign pm[2] = i_ports_c & PORT_MASK;

    assign share[PAIR_AB] = pm[0] & pm[1];
    assign share[PAIR_AC] = pm[0] & pm[2];
    assign share[PAIR_BC] = pm[1] & pm[2];
    assign all_share      = pm[0] & pm[1] & pm[2];

    always_comb begin
        plan = '0;
        best = 2'd0;
        have = 1'b0;
        tr   = '{PAIR_AB, PAIR_AB, PAIR_AB};
        ntry = 2'd0;
        sp   = PAIR_AB;
        done = 1'b0;
        unique case (i_k_count)
            K_ONE: begin
                // Cheapest present destination, earlier wins ties.
                for (int i = 0; i < 3; i++) begin
                    if (dv[i] != '0 && (!have || cv[i] < cv[best])) begin
                        best = 2'(i);
                        have = 1'b1;
                    end
                end
                plan.copies[0] = mk_single(SELS[best], pm[best]);
                plan.count     = 2'd1;
            end
            K_TWO: begin
                if (dv[2] == '0) begin
                    tr[0] = PAIR_AB;
                    ntry  = 2'd1;
                    sp    = PAIR_AB;
                end else if (cv[0] < cv[1]) begin
                    if (cv[1] < cv[2]) begin
                        tr[0] = PAIR_AB; ntry = 2'd1; sp = PAIR_AB;
                    end else if (cv[1] > cv[2]) begin
                        tr[0] = PAIR_AC; ntry = 2'd1; sp = PAIR_AC;
                    end else begin
                        tr[0] = PAIR_AC; tr[1] = PAIR_AB; ntry = 2'd2; sp = PAIR_AB;
                    end
                end else if (cv[0] > cv[1]) begin
                    if (cv[0] > cv[2]) begin
                        tr[0] = PAIR_BC; ntry = 2'd1; sp = PAIR_BC;
                    end else if (cv[0] < cv[2]) begin
                        tr[0] = PAIR_AB; ntry = 2'd1; sp = PAIR_AB;
                    end else begin
                        tr[0] = PAIR_AB; tr[1] = PAIR_BC; ntry = 2'd2; sp = PAIR_BC;
                    end
                end else begin
                    if (cv[2] > cv[0]) begin
                        tr[0] = PAIR_AB; ntry = 2'd1; sp = PAIR_AB;
                    end else if (cv[2] < cv[0]) begin
                        tr[0] = PAIR_AC; tr[1] = PAIR_BC; ntry = 2'd2; sp = PAIR_AC;
                    end else begin
                        tr[0] = PAIR_AB; tr[1] = PAIR_AC; tr[2] = PAIR_BC;
                        ntry  = 2'd3;
                        sp    = PAIR_AB;
                    end
                end
                // First pair in try order with a shared port wins.
                for (int i = 0; i < 3; i++) begin
                    if (!done && 2'(i) < ntry && share[tr[i]] != '0) begin
                        plan.copies[0] = mk_merge(SELS[PAIR_LO[tr[i]]],
                                                  SELS[PAIR_HI[tr[i]]], share[tr[i]]);
                        plan.count     = 2'd1;
                        done           = 1'b1;
                    end
                end
                if (!done) begin
                    plan.copies[0] = mk_single(SELS[PAIR_LO[sp]], pm[PAIR_LO[sp]]);
                    plan.copies[1] = mk_single(SELS[PAIR_HI[sp]], pm[PAIR_HI[sp]]);
                    plan.count     = 2'd2;
                end
            end
            K_THREE: begin
                if (all_share != '0) begin
                    plan.copies[0]       = '0;
                    plan.copies[0].port  = high_port(all_share);
                    plan.copies[0].k     = K_THREE;
                    plan.copies[0].sel_a = SEL_A;
                    plan.copies[0].sel_b = SEL_B;
                    plan.copies[0].sel_c = SEL_C;
                    plan.count           = 2'd1;
                end else if (share[PAIR_AB] != '0) begin
                    plan.copies[0] = mk_merge(SEL_A, SEL_B, share[PAIR_AB]);
                    plan.copies[1] = mk_single(SEL_C, pm[2]);
                    plan.count     = 2'd2;
                end else if (share[PAIR_AC] != '0) begin
                    plan.copies[0] = mk_merge(SEL_A, SEL_C, share[PAIR_AC]);
                    plan.copies[1] = mk_single(SEL_B, pm[1]);
                    plan.count     = 2'd2;
                end else if (share[PAIR_BC] != '0) begin
                    plan.copies[0] = mk_single(SEL_A, pm[0]);
                    plan.copies[1] = mk_merge(SEL_B, SEL_C, share[PAIR_BC]);
                    plan.count     = 2'd2;
                end else begin
                    plan.copies[0] = mk_single(SEL_A, pm[0]);
                    plan.copies[1] = mk_single(SEL_B, pm[1]);
                    plan.copies[2] = mk_single(SEL_C, pm[2]);
                    plan.count     = 2'd3;
                end
            end
            default: begin
                plan = '0;
            end
        endcase
    end

    assign o_stall = i_full;
    // Drop requests that produce no copy.
    assign o_push  = i_valid && !i_full && (plan.count != 2'd0);
    assign o_plan  = plan;

endmodule

### rtl/kfs_queue.sv
`timescale 1ns / 1ps

module kfs_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

### rtl/kfs_back.sv
`timescale 1ns / 1ps

module kfs_back
    import kfs_pkg::*;
#(
    parameter int ADDR_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_empty,
    input  t_plan                 i_plan,
    input  logic [ADDR_WIDTH-1:0] i_dest_a,
    input  logic [ADDR_WIDTH-1:0] i_dest_b,
    input  logic [ADDR_WIDTH-1:0] i_dest_c,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [PORT_IDX_W-1:0] o_out_port,
    output logic [K_W-1:0]        o_out_k,
    output logic [ADDR_WIDTH-1:0] o_out_dest_a,
    output logic [ADDR_WIDTH-1:0] o_out_dest_b,
    output logic [ADDR_WIDTH-1:0] o_out_dest_c,
    output logic                  o_last
);

    function automatic logic [ADDR_WIDTH-1:0] pick(input t_sel s,
                                                  input logic [ADDR_WIDTH-1:0] a,
                                                  input logic [ADDR_WIDTH-1:0] b,
                                                  input logic [ADDR_WIDTH-1:0] c);
        logic [ADDR_WIDTH-1:0] r;
        unique case (s)
            SEL_A:   r = a;
            SEL_B:   r = b;
            SEL_C:   r = c;
            default: r = '0;
        endcase
        return r;
    endfunction

    logic                  r_valid;
    logic [1:0]            r_idx, n_idx;
    logic [PORT_IDX_W-1:0] r_port;
    logic [K_W-1:0]        r_k;
    logic [ADDR_WIDTH-1:0] r_da, r_db, r_dc;
    logic                  r_last;
    logic                  advance;
    logic                  load;
    logic                  is_last;
    t_copy                 cur;

    assign advance = !r_valid || !i_stall;
    assign load    = advance && !i_empty;
    assign cur     = i_plan.copies[r_idx];
    assign is_last = (r_idx == i_plan.count - 2'd1);
    assign o_pop   = load && is_last;
    assign n_idx   = is_last ? 2'd0 : r_idx + 2'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (advance) begin
            r_valid <= !i_empty;
            if (load) begin
                r_idx <= n_idx;
            end
        end
    end

    // Hold the copy while the output is stalled.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_port <= cur.port;
            r_k    <= cur.k;
            r_da   <= pick(cur.sel_a, i_dest_a, i_dest_b, i_dest_c);
            r_db   <= pick(cur.sel_b, i_dest_a, i_dest_b, i_dest_c);
            r_dc   <= pick(cur.sel_c, i_dest_a, i_dest_b, i_dest_c);
            r_last <= is_last;
        end
    end

    assign o_valid      = r_valid;
    assign o_out_port   = r_port;
    assign o_out_k      = r_k;
    assign o_out_dest_a = r_da;
    assign o_out_dest_b = r_db;
    assign o_out_dest_c = r_dc;
    assign o_last       = r_last;

endmodule

### rtl/kanycast_forward_select.sv
`timescale 1ns / 1ps
// A request accepted into the queue shows its first copy at o_valid once the output register
// loads it from the queue head. Throughput: a request enters every cycle while the two-entry
// queue has room; the output register sends one copy per cycle while i_stall is low, so a
// request holds the back end for 1 to 3 copies, one slot per copy it produces.
// Reset (synchronous, active low) empties the queue and clears the output valid.
module kanycast_forward_select
    import kfs_pkg::*;
#(
    parameter int NUM_PORTS  = 8,
    parameter int ADDR_WIDTH = 16,
    parameter int COST_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [K_W-1:0]        i_k_count,
    input  logic [ADDR_WIDTH-1:0] i_dest_a,
    input  logic [ADDR_WIDTH-1:0] i_dest_b,
    input  logic [ADDR_WIDTH-1:0] i_dest_c,
    input  logic [COST_WIDTH-1:0] i_cost_a,
    input  logic [COST_WIDTH-1:0] i_cost_b,
    input  logic [COST_WIDTH-1:0] i_cost_c,
    input  logic [PORTMAP_W-1:0]  i_ports_a,
    input  logic [PORTMAP_W-1:0]  i_ports_b,
    input  logic [PORTMAP_W-1:0]  i_ports_c,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [PORT_IDX_W-1:0] o_out_port,
    output logic [K_W-1:0]        o_out_k,
    output logic [ADDR_WIDTH-1:0] o_out_dest_a,
    output logic [ADDR_WIDTH-1:0] o_out_dest_b,
    output logic [ADDR_WIDTH-1:0] o_out_dest_c,
    output logic                  o_last
);

    localparam int ENTRY_W = 3 * ADDR_WIDTH + $bits(t_plan);

    logic               push;
    logic               pop;
    logic               full;
    logic               empty;
    t_plan              front_plan;
    t_plan              head_plan;
    logic [ENTRY_W-1:0] wr_entry;
    logic [ENTRY_W-1:0] rd_entry;
    logic [ADDR_WIDTH-1:0] head_da, head_db, head_dc;

    kfs_front #(
        .NUM_PORTS  (NUM_PORTS),
        .ADDR_WIDTH (ADDR_WIDTH),
        .COST_WIDTH (COST_WIDTH)
    ) u_front (
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_k_count (i_k_count),
        .i_dest_a  (i_dest_a),
        .i_dest_b  (i_dest_b),
        .i_dest_c  (i_dest_c),
        .i_cost_a  (i_cost_a),
        .i_cost_b  (i_cost_b),
        .i_cost_c  (i_cost_c),
        .i_ports_a (i_ports_a),
        .i_ports_b (i_ports_b),
        .i_ports_c (i_ports_c),
        .i_full    (full),
        .o_push    (push),
        .o_plan    (front_plan)
    );

    assign wr_entry = {i_dest_a, i_dest_b, i_dest_c, front_plan};

    kfs_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (2)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (wr_entry),
        .i_pop   (pop),
        .o_data  (rd_entry),
        .o_full  (full),
        .o_empty (empty)
    );

    assign {head_da, head_db, head_dc, head_plan} = rd_entry;

    kfs_back #(
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (empty),
        .i_plan       (head_plan),
        .i_dest_a     (head_da),
        .i_dest_b     (head_db),
        .i_dest_c     (head_dc),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_port   (o_out_port),
        .o_out_k      (o_out_k),
        .o_out_dest_a (o_out_dest_a),
        .o_out_dest_b (o_out_dest_b),
        .o_out_dest_c (o_out_dest_c),
        .o_last       (o_last)
    );

endmodule
